// File: hw/rtl/fdcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdcsd_pkg
// Shared sizes, request codes and sequencer types of the flip-dot column
// sweep driver.
// ----------------------------------------------------------------------------
package fdcsd_pkg;

  // panel geometry
  localparam int GROUPS    = 2;               // bytes per line, 8 columns each
  localparam int LINES     = 5;               // pixel lines
  localparam int BPL       = 5;               // request bytes per panel
  localparam int COLS      = GROUPS * 8;
  localparam int PANELS    = GROUPS * 2;
  localparam int FRAME_LEN = LINES * GROUPS;
  localparam int REQ_LEN   = PANELS * BPL;

  localparam int FRAME_AW  = $clog2(FRAME_LEN);
  localparam int REQ_AW    = $clog2(REQ_LEN);
  localparam int LINE_W    = $clog2(BPL);
  localparam int PANEL_W   = $clog2(PANELS);
  localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam logic [3:0] PW_RESET = 4'd4;

  // host request codes
  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_FILL   = 3'd1,
    REQ_DRAW   = 3'd2,
    REQ_UPDATE = 3'd3,
    REQ_ABORT  = 3'd4,
    REQ_TICK   = 3'd5
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // memory pass kinds
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_FILL,
    OP_DRAW,
    OP_FLUSH,
    OP_SWEEP,
    OP_END
  } op_t;

  // frame byte index of a line within a group
  function automatic logic [FRAME_AW-1:0] frame_idx(input logic [LINE_W-1:0] line,
                                                    input logic [GRP_W-1:0]  grp);
    logic [FRAME_AW+LINE_W-1:0] prod;
    prod = (FRAME_AW+LINE_W)'(line) * (FRAME_AW+LINE_W)'(GROUPS);
    return prod[FRAME_AW-1:0] + FRAME_AW'(grp);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fdcsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdcsd_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module fdcsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/flip_dot_column_sweep_driver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flip_dot_column_sweep_driver_unit
// Flip-dot coil driver: frame store, shown store and coil request image held
// in memories, swept one column per tick and streamed out byte by byte.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Frame byte writes,
// update requests, aborts, idle ticks that start no flush and unused codes
// leave busy low. Fill, draw column and a sweep start with flush hold busy
// for one pass over the frame memory entries they touch, one entry per
// cycle, plus the write-back stage. A busy tick holds busy while the
// twenty request bytes are read, modified and written back one per cycle
// through the request memory port, and each modified byte leaves on the
// out_ ports for one cycle under out_valid, registered behind the write-back
// stage, the last one carrying out_latch. The receiver cannot stall the
// stream, so it must take every byte as it comes. After reset a clearing
// pass zeroes all three memories, holding busy high while it runs.
// cfg_ready is always high; power_width should only be written while the
// block is idle.
// ----------------------------------------------------------------------------
module flip_dot_column_sweep_driver_unit
  import fdcsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_req_type,
  input  wire logic [4:0] in_byte_index,
  input  wire logic [7:0] in_byte_value,
  input  wire logic [5:0] in_column,
  input  wire logic [4:0] in_column_bits,
  input  wire logic       in_flush,
  // result stream
  output logic            out_valid,
  output logic [7:0]      out_coil_byte,
  output logic            out_latch,
  output logic            out_busy_res,
  // configuration
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_power_width
);

  // sequencer state
  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [REQ_AW-1:0]    last_r, last_nxt;

  // read stage counters
  logic [REQ_AW-1:0]    a_idx_r, a_idx_nxt;
  logic [LINE_W-1:0]    a_li_r, a_li_nxt;
  logic [PANEL_W-1:0]   a_p_r, a_p_nxt;

  // write-back stage
  logic                 b_vld_r, b_vld_nxt;
  logic [REQ_AW-1:0]    b_idx_r, b_idx_nxt;
  logic [PANEL_W-1:0]   b_p_r, b_p_nxt;
  logic [LINE_W-1:0]    b_line_r, b_line_nxt;
  logic [FRAME_AW-1:0]  b_fi_r, b_fi_nxt;

  // per-pass operands
  logic [7:0]           val_r, val_nxt;
  logic [4:0]           bits_r, bits_nxt;
  logic [GRP_W-1:0]     pg_r, pg_nxt;
  logic [2:0]           pc_r, pc_nxt;
  logic [PANEL_W-1:0]   pp_r, pp_nxt;
  logic                 pon_r, pon_nxt;
  logic [PANEL_W-1:0]   rp_r, rp_nxt;
  logic [1:0]           rc_r, rc_nxt;
  logic                 ron_r, ron_nxt;
  logic                 end_abort_r, end_abort_nxt;
  logic                 busy_res_r, busy_res_nxt;

  // sweep bookkeeping
  logic                 sweep_busy_r, sweep_busy_nxt;
  logic                 upd_pend_r, upd_pend_nxt;
  logic                 flush_pend_r, flush_pend_nxt;
  logic                 abort_pend_r, abort_pend_nxt;
  logic [6:0]           col_r, col_nxt;
  logic [3:0]           pw_r, pw_nxt;

  // output registers
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_latch_r, out_latch_nxt;
  logic                 out_busy_r, out_busy_nxt;

  // combinational helpers
  logic                 accept;
  logic [LINE_W-1:0]    line_a;
  logic [FRAME_AW-1:0]  fi_a;
  logic [6:0]           pw7;
  logic [6:0]           rcol;
  logic                 end_cond;
  logic [GRP_W-1:0]     rg;

  // memory ports
  logic                 frame_we, shown_we, req_we;
  logic [FRAME_AW-1:0]  frame_waddr, frame_raddr, shown_waddr;
  logic [REQ_AW-1:0]    req_waddr;
  logic [7:0]           frame_wdata, shown_wdata, req_wdata;
  logic [7:0]           frame_rd, shown_rd, req_rd;

  // write-back compute
  logic                 src_bit, chg_bit, pow_hit, rx_hit;
  logic [1:0]           pair;
  logic [7:0]           set_mask, keep_mask, req_new, shown_new, draw_mask;

  assign accept    = start && !busy;
  assign busy      = (state_r == ST_RUN) || b_vld_r;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_coil_byte = out_byte_r;
  assign out_latch     = out_latch_r;
  assign out_busy_res  = out_busy_r;

  // read stage addressing: draw walks lines directly, the sweep walks the
  // request image where entry order is panel major, top line last
  assign line_a = (op_r == OP_DRAW) ? a_idx_r[LINE_W-1:0] : LINE_W'(BPL - 1) - a_li_r;
  assign fi_a   = frame_idx(line_a, pg_r);
  assign frame_raddr = (op_r == OP_FLUSH) ? a_idx_r[FRAME_AW-1:0] : fi_a;

  // sweep column decode for the tick being taken
  assign pw7      = 7'(pw_r);
  assign rcol     = col_r - pw7;
  assign end_cond = (col_r > 7'(COLS) + pw7) || abort_pend_r;
  assign rg       = rcol[3 +: GRP_W];

  fdcsd_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rd)
  );

  fdcsd_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_shown_ram (
    .clk   (clk),
    .we    (shown_we),
    .waddr (shown_waddr),
    .wdata (shown_wdata),
    .raddr (fi_a),
    .rdata (shown_rd)
  );

  fdcsd_ram #(.WIDTH(8), .DEPTH(REQ_LEN)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (req_wdata),
    .raddr (a_idx_r),
    .rdata (req_rd)
  );

  // write-back stage: coil pair for the powered column, relax mask for the
  // trailing column; power is applied before relax as both may hit one byte
  always_comb begin
    src_bit   = frame_rd[pc_r];
    chg_bit   = src_bit ^ shown_rd[pc_r];
    pair      = src_bit ? 2'b01 : 2'b10;
    pow_hit   = pon_r && (b_p_r == pp_r) && (b_line_r < LINE_W'(LINES));
    rx_hit    = ron_r && (b_p_r == rp_r) && (b_line_r < LINE_W'(LINES));
    set_mask  = (pow_hit && chg_bit) ? (8'(pair) << {pc_r[1:0], 1'b0}) : 8'h00;
    keep_mask = rx_hit ? ~(8'h03 << {rc_r, 1'b0}) : 8'hff;
    req_new   = (req_rd | set_mask) & keep_mask;
    shown_new = shown_rd;
    shown_new[pc_r] = src_bit;
    // draw column: bit i of the column lands on line LINES-1-i
    draw_mask = bits_r[LINE_W'(LINES - 1) - b_line_r] ? (8'h01 << pc_r) : 8'h00;
  end

  // memory write ports
  always_comb begin
    frame_we    = 1'b0;
    frame_waddr = b_fi_r;
    frame_wdata = 8'h00;
    shown_we    = 1'b0;
    shown_waddr = b_fi_r;
    shown_wdata = 8'h00;
    req_we      = 1'b0;
    req_waddr   = b_idx_r;
    req_wdata   = 8'h00;
    if (accept && (in_req_type == REQ_WRITE)) begin
      // frame byte writes go straight to memory, out of range ones are dropped
      frame_we    = (in_byte_index < 5'(FRAME_LEN));
      frame_waddr = in_byte_index[FRAME_AW-1:0];
      frame_wdata = in_byte_value;
    end else if (b_vld_r) begin
      unique case (op_r)
        OP_CLEAR: begin
          frame_we    = (b_idx_r < REQ_AW'(FRAME_LEN));
          frame_waddr = b_idx_r[FRAME_AW-1:0];
          shown_we    = (b_idx_r < REQ_AW'(FRAME_LEN));
          shown_waddr = b_idx_r[FRAME_AW-1:0];
          req_we      = 1'b1;
        end
        OP_FILL: begin
          frame_we    = 1'b1;
          frame_waddr = b_idx_r[FRAME_AW-1:0];
          frame_wdata = val_r;
        end
        OP_DRAW: begin
          frame_we    = 1'b1;
          frame_wdata = frame_rd | draw_mask;
        end
        OP_FLUSH: begin
          // shown becomes the inverse so every pixel reads as changed
          shown_we    = 1'b1;
          shown_waddr = b_idx_r[FRAME_AW-1:0];
          shown_wdata = ~frame_rd;
        end
        OP_SWEEP: begin
          shown_we    = pow_hit;
          shown_wdata = shown_new;
          req_we      = 1'b1;
          req_wdata   = req_new;
        end
        OP_END: begin
          // end of sweep or abort: relax every coil, abort also blanks frame
          frame_we    = end_abort_r && (b_idx_r < REQ_AW'(FRAME_LEN));
          frame_waddr = b_idx_r[FRAME_AW-1:0];
          req_we      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: request decode and pass control
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    a_idx_nxt      = a_idx_r;
    a_li_nxt       = a_li_r;
    a_p_nxt        = a_p_r;
    val_nxt        = val_r;
    bits_nxt       = bits_r;
    pg_nxt         = pg_r;
    pc_nxt         = pc_r;
    pp_nxt         = pp_r;
    pon_nxt        = pon_r;
    rp_nxt         = rp_r;
    rc_nxt         = rc_r;
    ron_nxt        = ron_r;
    end_abort_nxt  = end_abort_r;
    busy_res_nxt   = busy_res_r;
    sweep_busy_nxt = sweep_busy_r;
    upd_pend_nxt   = upd_pend_r;
    flush_pend_nxt = flush_pend_r;
    abort_pend_nxt = abort_pend_r;
    col_nxt        = col_r;
    pw_nxt         = cfg_valid ? cfg_power_width : pw_r;

    b_vld_nxt  = 1'b0;
    b_idx_nxt  = a_idx_r;
    b_p_nxt    = a_p_r;
    b_line_nxt = line_a;
    b_fi_nxt   = fi_a;

    unique case (state_r)
      ST_RUN: begin
        b_vld_nxt = 1'b1;
        if (a_idx_r == last_r) begin
          state_nxt = ST_IDLE;
          a_idx_nxt = '0;
          a_li_nxt  = '0;
          a_p_nxt   = '0;
        end else begin
          a_idx_nxt = a_idx_r + 1'b1;
          if (a_li_r == LINE_W'(BPL - 1)) begin
            a_li_nxt = '0;
            a_p_nxt  = a_p_r + 1'b1;
          end else begin
            a_li_nxt = a_li_r + 1'b1;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_FILL: begin
              state_nxt = ST_RUN;
              op_nxt    = OP_FILL;
              last_nxt  = REQ_AW'(FRAME_LEN - 1);
              val_nxt   = in_byte_value;
            end
            REQ_DRAW: begin
              if (in_column < 6'(COLS)) begin
                state_nxt = ST_RUN;
                op_nxt    = OP_DRAW;
                last_nxt  = REQ_AW'(LINES - 1);
                bits_nxt  = in_column_bits;
                pg_nxt    = in_column[3 +: GRP_W];
                pc_nxt    = in_column[2:0];
              end
            end
            REQ_UPDATE: begin
              upd_pend_nxt = 1'b1;
              if (in_flush) begin
                flush_pend_nxt = 1'b1;
              end
            end
            REQ_ABORT: begin
              abort_pend_nxt = 1'b1;
            end
            REQ_TICK: begin
              if (!sweep_busy_r) begin
                // idle tick: maybe start a sweep, no results
                if (upd_pend_r) begin
                  if (flush_pend_r) begin
                    state_nxt = ST_RUN;
                    op_nxt    = OP_FLUSH;
                    last_nxt  = REQ_AW'(FRAME_LEN - 1);
                  end
                  sweep_busy_nxt = 1'b1;
                  upd_pend_nxt   = 1'b0;
                  flush_pend_nxt = 1'b0;
                  abort_pend_nxt = 1'b0;
                  col_nxt        = '0;
                end
              end else begin
                state_nxt = ST_RUN;
                last_nxt  = REQ_AW'(REQ_LEN - 1);
                col_nxt   = col_r + 1'b1;
                if (end_cond) begin
                  op_nxt         = OP_END;
                  end_abort_nxt  = abort_pend_r;
                  busy_res_nxt   = 1'b0;
                  sweep_busy_nxt = 1'b0;
                  upd_pend_nxt   = 1'b0;
                  flush_pend_nxt = 1'b0;
                  abort_pend_nxt = 1'b0;
                end else begin
                  op_nxt       = OP_SWEEP;
                  busy_res_nxt = 1'b1;
                  // powered column
                  pon_nxt = (col_r < 7'(COLS));
                  pg_nxt  = col_r[3 +: GRP_W];
                  pc_nxt  = col_r[2:0];
                  pp_nxt  = PANEL_W'(PANELS - 1) - PANEL_W'({col_r[3 +: GRP_W], col_r[2]});
                  // relaxed column, power_width behind
                  ron_nxt = (col_r >= pw7) && (rcol < 7'(COLS));
                  rc_nxt  = rcol[1:0];
                  rp_nxt  = PANEL_W'(PANELS - 1) - PANEL_W'({rg, rcol[2]});
                end
              end
            end
            default: begin
              // frame writes are done at the port, unused codes do nothing
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result stream, one byte per write-back of a sweep or end pass
    out_valid_nxt = b_vld_r && ((op_r == OP_SWEEP) || (op_r == OP_END));
    out_byte_nxt  = (op_r == OP_SWEEP) ? req_new : 8'h00;
    out_latch_nxt = (b_idx_r == REQ_AW'(REQ_LEN - 1));
    out_busy_nxt  = busy_res_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;          // clearing pass after reset
      op_r         <= OP_CLEAR;
      last_r       <= REQ_AW'(REQ_LEN - 1);
      a_idx_r      <= '0;
      a_li_r       <= '0;
      a_p_r        <= '0;
      b_vld_r      <= 1'b0;
      sweep_busy_r <= 1'b0;
      upd_pend_r   <= 1'b0;
      flush_pend_r <= 1'b0;
      abort_pend_r <= 1'b0;
      col_r        <= '0;
      pw_r         <= PW_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      last_r       <= last_nxt;
      a_idx_r      <= a_idx_nxt;
      a_li_r       <= a_li_nxt;
      a_p_r        <= a_p_nxt;
      b_vld_r      <= b_vld_nxt;
      sweep_busy_r <= sweep_busy_nxt;
      upd_pend_r   <= upd_pend_nxt;
      flush_pend_r <= flush_pend_nxt;
      abort_pend_r <= abort_pend_nxt;
      col_r        <= col_nxt;
      pw_r         <= pw_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    b_idx_r     <= b_idx_nxt;
    b_p_r       <= b_p_nxt;
    b_line_r    <= b_line_nxt;
    b_fi_r      <= b_fi_nxt;
    val_r       <= val_nxt;
    bits_r      <= bits_nxt;
    pg_r        <= pg_nxt;
    pc_r        <= pc_nxt;
    pp_r        <= pp_nxt;
    pon_r       <= pon_nxt;
    rp_r        <= rp_nxt;
    rc_r        <= rc_nxt;
    ron_r       <= ron_nxt;
    end_abort_r <= end_abort_nxt;
    busy_res_r  <= busy_res_nxt;
    out_byte_r  <= out_byte_nxt;
    out_latch_r <= out_latch_nxt;
    out_busy_r  <= out_busy_nxt;
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flip-dot column sweep driver. Host requests are
// queued by a stimulus process and pushed by a clocked driver with random
// gaps. Each accepted request is run through a local panel model that predicts
// the twenty coil bytes streamed per busy tick. A clocked monitor compares
// every streamed byte against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import fdcsd_pkg::*;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // quiet cycles before a power width write, counted once nothing is in flight
  localparam int SETTLE_CYCLES = 25;
  localparam int MAX_REPORTS   = 10;

  typedef enum bit {
    HOST_REQ,
    HOST_CFG
  } host_kind_t;

  typedef struct {
    host_kind_t what;
    logic [2:0] req;
    logic [4:0] idx;
    logic [7:0] val;
    logic [5:0] col;
    logic [4:0] bits;
    logic       flush;
    logic [3:0] pw;
  } host_op_t;

  typedef struct packed {
    logic [7:0] coil;
    logic       latch;
    logic       busy_res;
  } coil_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel, all driven from time zero
  logic       start     = 1'b0;
  logic [2:0] req_d     = '0;
  logic [4:0] idx_d     = '0;
  logic [7:0] val_d     = '0;
  logic [5:0] col_d     = '0;
  logic [4:0] bits_d    = '0;
  logic       flush_d   = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [3:0] cfg_pw    = '0;

  logic       busy;
  logic       out_valid;
  logic [7:0] out_coil_byte;
  logic       out_latch;
  logic       out_busy_res;
  logic       cfg_ready;

  // queue of pending host operations and predicted coil stream
  host_op_t     host_requests[$];
  coil_result_t coil_bytes_due[$];

  int ops_total  = 0;
  int ops_done   = 0;
  int mismatches = 0;
  int results_seen = 0;

  // local panel model
  logic [7:0] frame_m [FRAME_LEN];
  logic [7:0] shown_m [FRAME_LEN];
  logic [7:0] coil_m  [REQ_LEN];
  logic       sweeping_m;
  logic       update_m;
  logic       flush_m;
  logic       abort_m;
  logic [6:0] sweep_col_m;
  logic [3:0] pw_m;

  flip_dot_column_sweep_driver_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (req_d),
    .in_byte_index   (idx_d),
    .in_byte_value   (val_d),
    .in_column       (col_d),
    .in_column_bits  (bits_d),
    .in_flush        (flush_d),
    .out_valid       (out_valid),
    .out_coil_byte   (out_coil_byte),
    .out_latch       (out_latch),
    .out_busy_res    (out_busy_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_power_width (cfg_pw)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // request byte position of one line of one half-group panel; panels are
  // shifted out last-first and lines bottom-up within a panel
  function automatic int coil_slot(int grp, int panel, int ln);
    return (PANELS - 1 - (2 * grp + panel)) * BPL + (BPL - 1 - ln);
  endfunction

  // apply one accepted request to the model, queue the bytes it streams
  task automatic advance_panel(input logic [2:0] kind, input logic [4:0] idx,
                               input logic [7:0] val, input logic [5:0] col,
                               input logic [4:0] bits, input logic fl);
    int i, ln, k, g, c, sh, fi, ri, rc;
    logic [7:0] src, chg, bitm, code, keep;
    coil_result_t r;
    case (kind)
      REQ_WRITE: begin
        if (idx < FRAME_LEN) frame_m[idx] = val;
      end
      REQ_FILL: begin
        for (i = 0; i < FRAME_LEN; i++) frame_m[i] = val;
      end
      REQ_DRAW: begin
        // bit 0 of the column lands on the bottom line
        if (col < COLS) begin
          for (i = 0; i < LINES; i++) begin
            if (bits[i]) begin
              fi = (LINES - 1 - i) * GROUPS + (col >> 3);
              frame_m[fi] = frame_m[fi] | 8'(1 << (col & 7));
            end
          end
        end
      end
      REQ_UPDATE: begin
        update_m = 1'b1;
        if (fl) flush_m = 1'b1;
      end
      REQ_ABORT: begin
        abort_m = 1'b1;
      end
      REQ_TICK: begin
        if (!sweeping_m) begin
          // idle tick: maybe start a sweep, never streams
          if (update_m) begin
            if (flush_m)
              for (i = 0; i < FRAME_LEN; i++) shown_m[i] = ~frame_m[i];
            sweeping_m  = 1'b1;
            update_m    = 1'b0;
            flush_m     = 1'b0;
            abort_m     = 1'b0;
            sweep_col_m = '0;
          end
        end else begin
          if (int'(sweep_col_m) > COLS + int'(pw_m) || abort_m) begin
            // sweep end or abort: every coil relaxed, abort also blanks frame
            for (i = 0; i < REQ_LEN; i++) coil_m[i] = '0;
            if (abort_m)
              for (i = 0; i < FRAME_LEN; i++) frame_m[i] = '0;
            sweeping_m = 1'b0;
            update_m   = 1'b0;
            flush_m    = 1'b0;
            abort_m    = 1'b0;
          end else begin
            // power the changed pixels of the current column
            if (sweep_col_m < COLS) begin
              g    = sweep_col_m >> 3;
              c    = sweep_col_m & 7;
              sh   = sweep_col_m & 4;
              bitm = 8'(1 << c);
              for (ln = 0; ln < LINES; ln++) begin
                fi   = ln * GROUPS + g;
                src  = frame_m[fi];
                chg  = bitm & (src ^ shown_m[fi]);
                ri   = coil_slot(g, c >> 2, ln);
                code = '0;
                for (k = 0; k < 4; k++)
                  if (chg[sh + k])
                    code = code | ((src[sh + k] ? 8'h01 : 8'h02) << (2 * k));
                coil_m[ri]  = coil_m[ri] | code;
                shown_m[fi] = (shown_m[fi] & ~bitm) | (src & bitm);
              end
            end
            // relax the column power_width behind
            if (sweep_col_m >= pw_m) begin
              rc = int'(sweep_col_m) - int'(pw_m);
              if (rc < COLS) begin
                g    = rc >> 3;
                c    = rc & 7;
                keep = ~(8'h03 << (2 * (c & 3)));
                for (ln = 0; ln < LINES; ln++) begin
                  ri = coil_slot(g, c >> 2, ln);
                  coil_m[ri] = coil_m[ri] & keep;
                end
              end
            end
          end
          sweep_col_m = sweep_col_m + 7'd1;
          // whole request image goes out, latch on the last byte
          for (i = 0; i < REQ_LEN; i++) begin
            r.coil     = coil_m[i];
            r.latch    = (i == REQ_LEN - 1);
            r.busy_res = sweeping_m;
            coil_bytes_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [2:0] kind, input logic [4:0] idx,
                           input logic [7:0] val, input logic [5:0] col,
                           input logic [4:0] bits, input logic fl);
    host_op_t op;
    op.what  = HOST_REQ;
    op.req   = kind;
    op.idx   = idx;
    op.val   = val;
    op.col   = col;
    op.bits  = bits;
    op.flush = fl;
    op.pw    = '0;
    host_requests.push_back(op);
  endtask

  task automatic queue_cfg(input logic [3:0] pw);
    host_op_t op;
    op.what  = HOST_CFG;
    op.req   = REQ_TICK;
    op.idx   = '0;
    op.val   = '0;
    op.col   = '0;
    op.bits  = '0;
    op.flush = 1'b0;
    op.pw    = pw;
    host_requests.push_back(op);
  endtask

  // request with the given code and random content in every field
  task automatic queue_any(input logic [2:0] kind);
    logic [4:0] idx;
    logic [5:0] col;
    // mostly in-range indexes and columns, some beyond the panel
    idx = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                      : 5'($urandom_range(0, FRAME_LEN - 1));
    col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                      : 6'($urandom_range(0, COLS - 1));
    queue_req(kind, idx, 8'($urandom), col, 5'($urandom), 1'($urandom));
  endtask

  // frame edit: byte writes and column draws, fills now and then
  task automatic queue_edit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      queue_any(REQ_WRITE);
    else if (r < 9)
      queue_any(REQ_DRAW);
    else
      queue_any(REQ_FILL);
  endtask

  // well-formed update: edits, update, starting tick, then a full sweep or an
  // abort part way through, with the odd edit or update mixed in
  task automatic queue_sweep(input int pw);
    int n, t, busy_ticks, abort_at;
    n = $urandom_range(1, 5);
    repeat (n) queue_edit();
    if ($urandom_range(0, 9) == 0) queue_any(REQ_ABORT);
    queue_any(REQ_UPDATE);
    queue_any(REQ_TICK);
    busy_ticks = COLS + pw + 2;
    abort_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, busy_ticks - 2) : -1;
    for (t = 0; t < busy_ticks; t++) begin
      if (t == abort_at) begin
        queue_any(REQ_ABORT);
        queue_any(REQ_TICK);
        break;
      end
      if ($urandom_range(0, 9) == 0) queue_edit();
      if ($urandom_range(0, 24) == 0) queue_any(REQ_UPDATE);
      queue_any(REQ_TICK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transfer per start/busy handshake, random gaps between
  // ---------------------------------------------------------------------------
  int gap_left    = 0;
  int calm_left   = 0;
  int quiet_count = 0;

  function automatic int next_gap();
    int r;
    // stretches of back-to-back requests
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin : drive_host
    int i;
    bit took;
    host_op_t op;
    took = 1'b0;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left    = 0;
      quiet_count = 0;
      for (i = 0; i < FRAME_LEN; i++) begin
        frame_m[i] = '0;
        shown_m[i] = '0;
      end
      for (i = 0; i < REQ_LEN; i++) coil_m[i] = '0;
      sweeping_m  = 1'b0;
      update_m    = 1'b0;
      flush_m     = 1'b0;
      abort_m     = 1'b0;
      sweep_col_m = '0;
      pw_m        = PW_RESET;
    end else begin
      // request transfer at this edge
      if (start && !busy) begin
        advance_panel(req_d, idx_d, val_d, col_d, bits_d, flush_d);
        ops_done++;
        took = 1'b1;
        gap_left = next_gap();
      end

      // block counts as settled only after a run of idle cycles with
      // nothing in flight and nothing left to stream
      if (busy || start || coil_bytes_due.size() != 0)
        quiet_count = 0;
      else
        quiet_count++;

      if (cfg_valid && cfg_ready) begin
        // power width transfer
        pw_m = cfg_pw;
        ops_done++;
        cfg_valid <= 1'b0;
      end else if (!cfg_valid && (!start || took)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (host_requests.size() == 0) begin
          start <= 1'b0;
        end else if (host_requests[0].what == HOST_CFG) begin
          // register writes only once the block has gone quiet
          start <= 1'b0;
          if (quiet_count >= SETTLE_CYCLES) begin
            op = host_requests.pop_front();
            cfg_pw    <= op.pw;
            cfg_valid <= 1'b1;
          end
        end else begin
          op = host_requests.pop_front();
          req_d   <= op.req;
          idx_d   <= op.idx;
          val_d   <= op.val;
          col_d   <= op.col;
          bits_d  <= op.bits;
          flush_d <= op.flush;
          start   <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: the stream cannot be stalled, every strobe is a transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_coils
    coil_result_t e;
    if (rst_n && out_valid) begin
      if (coil_bytes_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected coil byte %0d: coil %02h latch %0b busy %0b",
                   results_seen, out_coil_byte, out_latch, out_busy_res);
        mismatches++;
      end else begin
        e = coil_bytes_due.pop_front();
        if (out_coil_byte !== e.coil || out_latch !== e.latch ||
            out_busy_res !== e.busy_res) begin
          if (mismatches < MAX_REPORTS)
            $display("coil byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     results_seen, e.coil, e.latch, e.busy_res,
                     out_coil_byte, out_latch, out_busy_res);
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0] phase_pw [6];
    int p, target, guard;

    // directed: index and column extremes, every code, idle abort and tick,
    // flush, edits and updates during a sweep, abort mid-sweep
    queue_cfg(4'd1);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_ABORT,   5'd31, 8'hff, 6'd63, 5'h1f, 1'b1);
    queue_req(REQ_FILL,    5'd0,  8'ha5, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_WRITE,   5'd0,  8'hff, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_WRITE,   5'd9,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_WRITE,   5'd10, 8'h5a, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_WRITE,   5'd31, 8'hff, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_DRAW,    5'd0,  8'h00, 6'd0,  5'h1f, 1'b0);
    queue_req(REQ_DRAW,    5'd0,  8'h00, 6'd15, 5'h01, 1'b0);
    queue_req(REQ_DRAW,    5'd0,  8'h00, 6'd16, 5'h1f, 1'b0);
    queue_req(REQ_DRAW,    5'd0,  8'h00, 6'd63, 5'h1f, 1'b0);
    queue_req(REQ_SPARE_A, 5'd31, 8'hff, 6'd63, 5'h1f, 1'b1);
    queue_req(REQ_SPARE_B, 5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_UPDATE,  5'd0,  8'h00, 6'd0,  5'h00, 1'b1);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_WRITE,   5'd3,  8'h0f, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_UPDATE,  5'd0,  8'h00, 6'd0,  5'h00, 1'b1);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_ABORT,   5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);
    queue_req(REQ_TICK,    5'd0,  8'h00, 6'd0,  5'h00, 1'b0);

    // random phases, power width extremes first, zero included
    phase_pw[0] = 4'd15;
    phase_pw[1] = 4'd0;
    phase_pw[2] = PW_RESET;
    phase_pw[3] = 4'($urandom_range(1, 14));
    phase_pw[4] = 4'd1;
    phase_pw[5] = 4'($urandom_range(0, 15));
    for (p = 0; p < 6; p++) begin
      queue_cfg(phase_pw[p]);
      target = host_requests.size() + 65;
      while (host_requests.size() < target) begin
        // mostly clean update sequences, the rest loose noise
        if ($urandom_range(0, 3) != 0)
          queue_sweep(phase_pw[p]);
        else
          repeat ($urandom_range(1, 4)) queue_any(3'($urandom_range(0, 7)));
      end
    end
    ops_total = host_requests.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_done < ops_total) @(posedge clk);
    guard = 0;
    while (coil_bytes_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    if (mismatches == 0 && coil_bytes_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: flip_dot_column_sweep_driver_unit.f
hw/rtl/fdcsd_pkg.sv
hw/rtl/fdcsd_ram.sv
hw/rtl/flip_dot_column_sweep_driver_unit.sv
tb/tb.sv
